[hw/rtl/tls_sni_extractor_macros.svh]
`ifndef TLS_SNI_EXTRACTOR_MACROS_SVH
`define TLS_SNI_EXTRACTOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tse check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define TSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tse check failed");

`endif

[hw/rtl/tse_pkg.sv]
package tse_pkg;

  typedef enum logic [3:0] {
    PH_WAIT    = 4'd0,
    PH_TYPE_HI = 4'd1,
    PH_TYPE_LO = 4'd2,
    PH_LEN_HI  = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_SKIP    = 4'd5,
    PH_SKIP3   = 4'd6,
    PH_NAME_HI = 4'd7,
    PH_NAME_LO = 4'd8,
    PH_NAME    = 4'd9,
    PH_DONE    = 4'd10
  } phase_e;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RECORD_TYPE_POS    = 2'd0;
  localparam cfg_idx_t CFG_HANDSHAKE_TYPE_POS = 2'd1;
  localparam cfg_idx_t CFG_EXT_SIZE_POS       = 2'd2;
  localparam cfg_idx_t CFG_EXT_DATA_POS       = 2'd3;

  localparam logic [7:0]  REC_HANDSHAKE = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [15:0] EXT_SERVER_NAME = 16'd0;
  localparam logic [15:0] SNI_LIST_SKIP = 16'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
    logic       name_last;
    logic       name_found;
    logic       client_hello;
  } beat_t;

endpackage

[hw/rtl/tls_sni_extractor.sv]
// Beats of an accepted byte enter the output queue at the edge that accepts it, behind older beats.
// Throughput: one byte per cycle while the output side takes one beat per cycle;
//   a byte that yields a name beat and a status beat puts both beats into the queue.
// Input is taken while the four-entry output queue has room for two beats.
// Reset (rst_ni low, asynchronous) empties the queue, clears per-packet state
//   and loads the position registers with 0, 5, 0 and 2.
module tls_sni_extractor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  tse_pkg::cfg_idx_t cfg_addr_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] packet_byte
  input  logic              s_axis_tlast_i,   // packet_end
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [15:0]       m_axis_tdata_o,   // [7:0] name_byte, [8] name_found,
                                              // [9] client_hello, [15:10] zero
  output logic              m_axis_tlast_o,   // name_last
  output logic              m_axis_tuser_o    // kind
);
  import tse_pkg::*;

  logic [15:0] rec_pos_q, hs_pos_q, size_pos_q, data_pos_q;

  logic [15:0] byte_pos_q, byte_pos_d;
  phase_e      phase_q, phase_d;
  logic [15:0] ext_total_q, ext_total_d;
  logic [16:0] ext_used_q, ext_used_d;
  logic [15:0] field_left_q, field_left_d;
  logic [15:0] ext_kind_q, ext_kind_d;
  logic [7:0]  high_byte_q, high_byte_d;
  logic [1:0]  hello_q, hello_d;
  logic        found_q, found_d;

  logic        name_vld;
  beat_t       name_beat, stat_beat, push0, push1;
  logic [1:0]  n_push;

  beat_t       fifo_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;
  logic        accept, pop;

  assign s_axis_tready_o = (cnt_q <= 3'd2);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_pos_q  <= 16'd0;
      hs_pos_q   <= 16'd5;
      size_pos_q <= 16'd0;
      data_pos_q <= 16'd2;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_RECORD_TYPE_POS:    rec_pos_q  <= cfg_wdata_i;
        CFG_HANDSHAKE_TYPE_POS: hs_pos_q   <= cfg_wdata_i;
        CFG_EXT_SIZE_POS:       size_pos_q <= cfg_wdata_i;
        CFG_EXT_DATA_POS:       data_pos_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [15:0] fl_dec;
    b            = s_axis_tdata_i;
    byte_pos_d   = byte_pos_q;
    phase_d      = phase_q;
    ext_total_d  = ext_total_q;
    ext_used_d   = ext_used_q;
    field_left_d = field_left_q;
    ext_kind_d   = ext_kind_q;
    high_byte_d  = high_byte_q;
    hello_d      = hello_q;
    found_d      = found_q;
    name_vld     = 1'b0;
    fl_dec       = field_left_q - 16'd1;

    if (byte_pos_q == rec_pos_q)          hello_d[0] = (b == REC_HANDSHAKE);
    if (byte_pos_q == hs_pos_q)           hello_d[1] = (b == HS_CLIENT_HELLO);
    if (byte_pos_q == size_pos_q)         ext_total_d[15:8] = b;
    if (byte_pos_q == size_pos_q + 16'd1) ext_total_d[7:0] = b;

    if (phase_q == PH_WAIT && byte_pos_q == data_pos_q) begin
      phase_d    = PH_TYPE_HI;
      ext_used_d = 17'd0;
    end

    if (phase_d != PH_WAIT && phase_d != PH_DONE) begin
      if (phase_d == PH_TYPE_HI && ext_used_d >= {1'b0, ext_total_d}) begin
        phase_d = PH_DONE;
      end else begin
        ext_used_d = ext_used_d + 17'd1;
        case (phase_d)
          PH_TYPE_HI: begin
            high_byte_d = b;
            phase_d     = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            ext_kind_d = {high_byte_q, b};
            phase_d    = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            high_byte_d = b;
            phase_d     = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            field_left_d = {high_byte_q, b};
            if (ext_kind_q == EXT_SERVER_NAME) begin
              field_left_d = SNI_LIST_SKIP;
              phase_d      = PH_SKIP3;
            end else if (field_left_d == 16'd0) begin
              phase_d = PH_TYPE_HI;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_SKIP: begin
            field_left_d = fl_dec;
            if (fl_dec == 16'd0) phase_d = PH_TYPE_HI;
          end
          PH_SKIP3: begin
            field_left_d = fl_dec;
            if (fl_dec == 16'd0) phase_d = PH_NAME_HI;
          end
          PH_NAME_HI: begin
            high_byte_d = b;
            phase_d     = PH_NAME_LO;
          end
          PH_NAME_LO: begin
            field_left_d = {high_byte_q, b};
            phase_d      = (field_left_d == 16'd0) ? PH_DONE : PH_NAME;
          end
          PH_NAME: begin
            field_left_d = fl_dec;
            name_vld     = 1'b1;
            if (fl_dec == 16'd0) begin
              found_d = 1'b1;
              phase_d = PH_DONE;
            end
          end
          default: phase_d = PH_DONE;
        endcase
      end
    end

    byte_pos_d = byte_pos_q + 16'd1;

    name_beat = '{kind: 1'b0, name_byte: b, name_last: (fl_dec == 16'd0),
                  name_found: 1'b0, client_hello: 1'b0};
    stat_beat = '{kind: 1'b1, name_byte: 8'd0, name_last: 1'b0,
                  name_found: found_d, client_hello: (hello_d == 2'b11)};

    if (s_axis_tlast_i) begin
      byte_pos_d   = 16'd0;
      phase_d      = PH_WAIT;
      ext_total_d  = 16'd0;
      ext_used_d   = 17'd0;
      field_left_d = 16'd0;
      ext_kind_d   = 16'd0;
      high_byte_d  = 8'd0;
      hello_d      = 2'b00;
      found_d      = 1'b0;
    end

    push0  = name_vld ? name_beat : stat_beat;
    push1  = stat_beat;
    n_push = {1'b0, name_vld} + {1'b0, s_axis_tlast_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= 16'd0;
      phase_q      <= PH_WAIT;
      ext_total_q  <= 16'd0;
      ext_used_q   <= 17'd0;
      field_left_q <= 16'd0;
      ext_kind_q   <= 16'd0;
      high_byte_q  <= 8'd0;
      hello_q      <= 2'b00;
      found_q      <= 1'b0;
    end else if (accept) begin
      byte_pos_q   <= byte_pos_d;
      phase_q      <= phase_d;
      ext_total_q  <= ext_total_d;
      ext_used_q   <= ext_used_d;
      field_left_q <= field_left_d;
      ext_kind_q   <= ext_kind_d;
      high_byte_q  <= high_byte_d;
      hello_q      <= hello_d;
      found_q      <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && n_push != 2'd0) fifo_q[wr_q] <= push0;
    if (accept && n_push == 2'd2) fifo_q[wr_q + 2'd1] <= push1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (accept) wr_q <= wr_q + n_push;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + (accept ? {1'b0, n_push} : 3'd0) - {2'b00, pop};
    end
  end

  assign m_axis_tuser_o = fifo_q[rd_q].kind;
  assign m_axis_tlast_o = fifo_q[rd_q].name_last;
  assign m_axis_tdata_o = {6'd0, fifo_q[rd_q].client_hello, fifo_q[rd_q].name_found,
                           fifo_q[rd_q].name_byte};

endmodule

[hw/rtl/tse_checker.sv]
`include "tls_sni_extractor_macros.svh"

module tse_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              s_axis_tlast_i,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [15:0]       m_axis_tdata_o,
  input logic              m_axis_tlast_o,
  input logic              m_axis_tuser_o
);

  // a status beat carries no name byte and never closes a name
  `TSE_ASSERT_IMP(a_status_clean, m_axis_tvalid_o && m_axis_tuser_o,
                  !m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'd0)

  // a name beat carries no status flags
  `TSE_ASSERT_IMP(a_name_clean, m_axis_tvalid_o && !m_axis_tuser_o,
                  m_axis_tdata_o[15:8] == 8'd0)

  // a packet end always leaves a status beat waiting on the next cycle
  `TSE_ASSERT_NXT(a_end_gives_status,
                  s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i,
                  m_axis_tvalid_o)

  // stalled beat holds
  `TSE_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                  m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
                  && $stable(m_axis_tlast_o))

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (.*);

[tb/sv/tse_tb_pkg.sv]
`timescale 1ns / 1ps

package tse_tb_pkg;
  import tse_pkg::*;

  class sni_scoreboard;
    logic [15:0] rec_at;
    logic [15:0] hs_at;
    logic [15:0] size_at;
    logic [15:0] ext_at;

    logic [15:0] offset;
    phase_e      walk;
    logic [15:0] ext_size;
    logic [16:0] ext_seen;
    logic [15:0] remain;
    logic [15:0] ext_type;
    logic [7:0]  msb;
    logic [1:0]  hello_bits;
    logic        name_done;

    beat_t pending[$];
    int    errors;
    int    name_beats;
    int    status_beats;
    int    hellos;
    int    names_found;

    function new();
      rec_at       = 16'd0;
      hs_at        = 16'd5;
      size_at      = 16'd0;
      ext_at       = 16'd2;
      errors       = 0;
      name_beats   = 0;
      status_beats = 0;
      hellos       = 0;
      names_found  = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      offset     = '0;
      walk       = PH_WAIT;
      ext_size   = '0;
      ext_seen   = '0;
      remain     = '0;
      ext_type   = '0;
      msb        = '0;
      hello_bits = '0;
      name_done  = 1'b0;
    endfunction

    function void set_reg(input cfg_idx_t idx, input logic [15:0] v);
      case (idx)
        CFG_RECORD_TYPE_POS:    rec_at = v;
        CFG_HANDSHAKE_TYPE_POS: hs_at = v;
        CFG_EXT_SIZE_POS:       size_at = v;
        CFG_EXT_DATA_POS:       ext_at = v;
        default: ;
      endcase
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      beat_t       e;
      logic [15:0] size_lo_at;
      size_lo_at = size_at + 16'd1;
      if (offset == rec_at) hello_bits[0] = (b == REC_HANDSHAKE);
      if (offset == hs_at) hello_bits[1] = (b == HS_CLIENT_HELLO);
      if (offset == size_at) ext_size[15:8] = b;
      if (offset == size_lo_at) ext_size[7:0] = b;
      if (walk == PH_WAIT && offset == ext_at) begin
        walk     = PH_TYPE_HI;
        ext_seen = '0;
      end
      if (walk >= PH_TYPE_HI && walk <= PH_NAME) begin
        if (walk == PH_TYPE_HI && ext_seen >= {1'b0, ext_size}) begin
          walk = PH_DONE;
        end else begin
          ext_seen = ext_seen + 17'd1;
          case (walk)
            PH_TYPE_HI: begin
              msb  = b;
              walk = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
              ext_type = {msb, b};
              walk     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              msb  = b;
              walk = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              remain = {msb, b};
              if (ext_type == EXT_SERVER_NAME) begin
                remain = SNI_LIST_SKIP;
                walk   = PH_SKIP3;
              end else if (remain == 16'd0) begin
                walk = PH_TYPE_HI;
              end else begin
                walk = PH_SKIP;
              end
            end
            PH_SKIP: begin
              remain = remain - 16'd1;
              if (remain == 16'd0) walk = PH_TYPE_HI;
            end
            PH_SKIP3: begin
              remain = remain - 16'd1;
              if (remain == 16'd0) walk = PH_NAME_HI;
            end
            PH_NAME_HI: begin
              msb  = b;
              walk = PH_NAME_LO;
            end
            PH_NAME_LO: begin
              remain = {msb, b};
              if (remain == 16'd0) walk = PH_DONE;
              else walk = PH_NAME;
            end
            default: begin
              remain      = remain - 16'd1;
              e           = '0;
              e.name_byte = b;
              e.name_last = (remain == 16'd0);
              pending.push_back(e);
              name_beats++;
              if (remain == 16'd0) begin
                name_done = 1'b1;
                walk      = PH_DONE;
              end
            end
          endcase
        end
      end
      offset = offset + 16'd1;
      if (last) begin
        e              = '0;
        e.kind         = 1'b1;
        e.name_found   = name_done;
        e.client_hello = (hello_bits == 2'b11);
        pending.push_back(e);
        status_beats++;
        if (e.client_hello) hellos++;
        if (e.name_found) names_found++;
        clear_packet();
      end
    endfunction

    function void check_beat(input beat_t got, input logic [5:0] pad);
      beat_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected beat kind=%0d byte=%02h last=%0d found=%0d hello=%0d pad=%02h",
                   $time, got.kind, got.name_byte, got.name_last, got.name_found,
                   got.client_hello, pad);
        return;
      end
      want = pending.pop_front();
      if (got !== want || pad !== 6'd0) begin
        errors++;
        if (errors <= 20) begin
          $write("%0t: beat mismatch expected kind=%0d byte=%02h last=%0d found=%0d hello=%0d,",
                 $time, want.kind, want.name_byte, want.name_last, want.name_found,
                 want.client_hello);
          $display(" got kind=%0d byte=%02h last=%0d found=%0d hello=%0d pad=%02h",
                   got.kind, got.name_byte, got.name_last, got.name_found,
                   got.client_hello, pad);
        end
      end
    endfunction
  endclass

endpackage

[tb/sv/tb_tls_sni_extractor.sv]
`timescale 1ns / 1ps

module tb_tls_sni_extractor;
  import tse_pkg::*;
  import tse_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef enum {
    PK_GOOD,
    PK_NAME_AT_END,
    PK_CUT,
    PK_EMPTY,
    PK_BAD_SIZE,
    PK_NOT_HELLO,
    PK_NOISE
  } pkt_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  cfg_idx_t    cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  sni_scoreboard sb;
  logic [7:0]    frame[];
  bit            idle_on;
  int            beats_taken;
  int            bytes_sent;
  int            packets_sent;
  int            longest;
  int            settings;

  tls_sni_extractor i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_beat({m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tlast_o,
                     m_axis_tdata_o[8], m_axis_tdata_o[9]}, m_axis_tdata_o[15:10]);
      beats_taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("tls_sni_extractor test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pkt_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return PK_GOOD;
    if (r < 60) return PK_NAME_AT_END;
    if (r < 70) return PK_CUT;
    if (r < 75) return PK_EMPTY;
    if (r < 85) return PK_BAD_SIZE;
    if (r < 92) return PK_NOT_HELLO;
    return PK_NOISE;
  endfunction

  initial begin : rx_proc
    int  hold;
    bit  held;
    m_axis_tready_i = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = pick_gap();
      if (!held && beats_taken >= 60) begin
        held = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_packet();
    int i;
    for (i = 0; i < frame.size(); i++)
      send_byte(frame[i], i == frame.size() - 1, pick_gap());
    packets_sent++;
    if (frame.size() > longest) longest = frame.size();
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] rec, input logic [15:0] hs,
                            input logic [15:0] size, input logic [15:0] ext);
    drain();
    put_reg(CFG_RECORD_TYPE_POS, rec);
    put_reg(CFG_HANDSHAKE_TYPE_POS, hs);
    put_reg(CFG_EXT_SIZE_POS, size);
    put_reg(CFG_EXT_DATA_POS, ext);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic build_packet(input pkt_kind_e kind);
    logic [7:0]  ext[$];
    logic [15:0] nlen;
    logic [15:0] elen;
    logic [15:0] tag;
    logic [15:0] size_val;
    logic [15:0] size_lo_at;
    logic [7:0]  flip;
    int          n_pre;
    int          n_post;
    int          name_end;
    int          len;
    int          hdr_min;
    int          i;
    int          k;
    bit          bad_rec;

    if (kind == PK_NOISE || sb.ext_at > 200) begin
      len = $urandom_range(1, 30);
      frame = new[len];
      foreach (frame[i]) frame[i] = 8'($urandom_range(0, 255));
      return;
    end

    if (kind == PK_EMPTY) nlen = 16'd0;
    else if ($urandom_range(0, 29) == 0) nlen = 16'($urandom_range(256, 280));
    else nlen = 16'($urandom_range(1, 12));
    n_pre  = $urandom_range(0, 2);
    n_post = (kind == PK_NAME_AT_END) ? 0 : $urandom_range(0, 1);
    name_end = 0;

    for (k = 0; k <= n_pre + n_post; k++) begin
      if (k == n_pre) begin
        elen = nlen + 16'd5;
        ext.push_back(EXT_SERVER_NAME[15:8]);
        ext.push_back(EXT_SERVER_NAME[7:0]);
        ext.push_back(elen[15:8]);
        ext.push_back(elen[7:0]);
        repeat (3) ext.push_back(8'($urandom_range(0, 255)));
        ext.push_back(nlen[15:8]);
        ext.push_back(nlen[7:0]);
        repeat (nlen) ext.push_back(8'($urandom_range(0, 255)));
        name_end = ext.size();
      end else begin
        tag  = 16'($urandom_range(1, 65535));
        elen = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
        ext.push_back(tag[15:8]);
        ext.push_back(tag[7:0]);
        ext.push_back(elen[15:8]);
        ext.push_back(elen[7:0]);
        repeat (elen) ext.push_back(8'($urandom_range(0, 255)));
      end
    end

    size_val = 16'(ext.size());
    if (kind == PK_BAD_SIZE)
      size_val = $urandom_range(0, 1) ? 16'($urandom_range(0, ext.size()))
                                      : 16'($urandom_range(0, 65535));

    size_lo_at = sb.size_at + 16'd1;
    hdr_min = 0;
    if (sb.rec_at < 200 && sb.rec_at + 1 > hdr_min) hdr_min = sb.rec_at + 1;
    if (sb.hs_at < 200 && sb.hs_at + 1 > hdr_min) hdr_min = sb.hs_at + 1;
    if (sb.size_at < 200 && sb.size_at + 1 > hdr_min) hdr_min = sb.size_at + 1;
    if (size_lo_at < 200 && size_lo_at + 1 > hdr_min) hdr_min = size_lo_at + 1;

    case (kind)
      PK_NAME_AT_END: len = sb.ext_at + name_end;
      PK_CUT:         len = sb.ext_at + $urandom_range(1, name_end - 1);
      default: begin
        len = sb.ext_at + ext.size() + $urandom_range(0, 3);
        if (len < hdr_min) len = hdr_min;
      end
    endcase

    frame = new[len];
    foreach (frame[i]) frame[i] = 8'($urandom_range(0, 255));
    for (i = 0; i < ext.size(); i++)
      if (sb.ext_at + i < len) frame[sb.ext_at + i] = ext[i];

    bad_rec = 1'($urandom_range(0, 1));
    flip    = 8'($urandom_range(1, 255));
    if (sb.size_at < len) frame[sb.size_at] = size_val[15:8];
    if (size_lo_at < len) frame[size_lo_at] = size_val[7:0];
    if (sb.rec_at < len)
      frame[sb.rec_at] = (kind == PK_NOT_HELLO && bad_rec) ? REC_HANDSHAKE ^ flip
                                                            : REC_HANDSHAKE;
    if (sb.hs_at < len)
      frame[sb.hs_at] = (kind == PK_NOT_HELLO && !bad_rec) ? HS_CLIENT_HELLO ^ flip
                                                           : HS_CLIENT_HELLO;
  endtask

  initial begin : main
    int        ph;
    int        quota;
    int        start;
    pkt_kind_e kind;

    sb = new();
    cfg_we_i        = 1'b0;
    cfg_addr_i      = CFG_RECORD_TYPE_POS;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    idle_on         = 1'b1;
    beats_taken     = 0;
    bytes_sent      = 0;
    packets_sent    = 0;
    longest         = 0;
    settings        = 0;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_config(16'd0, 16'd1, 16'd2, 16'd4);
    frame = new[1];
    frame[0] = 8'h00;
    send_packet();
    frame[0] = 8'hFF;
    send_packet();
    for (kind = PK_GOOD; kind <= PK_NOISE; kind = kind.next()) begin
      build_packet(kind);
      send_packet();
      if (kind == PK_NOISE) break;
    end

    for (ph = 0; ph < 11; ph++) begin
      case (ph)
        0:  set_config(16'd0, 16'd5, 16'd0, 16'd2);
        8:  set_config(16'd0, 16'd0, 16'd0, 16'd0);
        9:  set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        10: set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        default: begin
          if (ph % 2)
            set_config(16'($urandom_range(0, 3)), 16'($urandom_range(4, 6)),
                       16'($urandom_range(7, 9)), 16'($urandom_range(11, 14)));
          else
            set_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                       16'($urandom_range(0, 15)), 16'($urandom_range(0, 20)));
        end
      endcase
      idle_on = (ph % 3 != 2);
      quota   = (ph >= 9) ? 30 : 80;
      start   = bytes_sent;
      while (bytes_sent - start < quota) begin
        build_packet(pick_kind());
        send_packet();
      end
    end
    drain();

    $display("covered %0d packets, %0d bytes, %0d register settings, longest packet %0d bytes",
             packets_sent, bytes_sent, settings, longest);
    $display("host name beats %0d, status beats %0d, ClientHello statuses %0d, complete names %0d",
             sb.name_beats, sb.status_beats, sb.hellos, sb.names_found);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tls_sni_extractor test passed");
    end else begin
      $display("tls_sni_extractor test failed");
    end
    $finish;
  end

endmodule
